@@ design/rumble_unlock_sequence_detector_macros.svh @@
// Assertion macros shared by the rumble unlock detector RTL.
// Included by name from the files that carry concurrent checks.
`ifndef RUMBLE_UNLOCK_SEQUENCE_DETECTOR_MACROS_SVH
`define RUMBLE_UNLOCK_SEQUENCE_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RUSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rusd: implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define RUSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rusd: next-cycle check failed");

`endif

@@ design/rusd_pkg.sv @@
// Types, codes and constants of the rumble unlock sequence detector.
// No dependencies; used by rusd_step and the top level.
`default_nettype none

package rusd_pkg;

    // Width of the off-delay millisecond counter
    localparam int DELAY_BITS = 16;
    localparam int CFG_BITS   = 16;
    // Compare width for counter against off_delay
    localparam int CMP_W      = (DELAY_BITS > CFG_BITS) ? DELAY_BITS : CFG_BITS;

    localparam logic [CFG_BITS-1:0] OFF_DELAY_RST = 16'd400;

    // Item kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Bus addresses of the unlock sequence
    localparam logic [31:0] A_START   = 32'h09FE_0000;
    localparam logic [31:0] A_STEP1   = 32'h0800_0000;
    localparam logic [31:0] A_STEP2   = 32'h0802_0000;
    localparam logic [31:0] A_STEP3   = 32'h0804_0000;
    localparam logic [31:0] A_SELECT  = 32'h09E2_0000;
    localparam logic [31:0] A_COMMIT  = 32'h09FC_0000;
    localparam logic [31:0] A_END_CMD = 32'h0800_1000;

    // Bus values of the unlock sequence
    localparam logic [15:0] V_D200     = 16'hD200;
    localparam logic [15:0] V_1500     = 16'h1500;
    localparam logic [15:0] V_SHORTCUT = 16'h0008;
    localparam logic [15:0] V_SEL_F1   = 16'h00F1;
    localparam logic [7:0]  B_SEL_7    = 8'h07;
    localparam logic [7:0]  B_SEL_8    = 8'h08;
    localparam logic [7:0]  B_MODE_ON  = 8'h02;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_STEP1 = 3'd1,
        ST_STEP2 = 3'd2,
        ST_STEP3 = 3'd3,
        ST_SEL   = 3'd4,
        ST_CMT   = 3'd5,
        ST_END   = 3'd6
    } stage_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_OFF  = 2'd1,
        MODE_ON   = 2'd2
    } mode_t;

    typedef struct packed {
        logic        action;
        logic [31:0] bus_address;
        logic [31:0] bus_value;
    } item_t;

    typedef struct packed {
        logic       motor_on;
        logic [2:0] sequence_stage;
        logic       commit_seen;
    } result_t;

    typedef struct packed {
        stage_t                stage;
        mode_t                 mode;
        logic                  off_armed;
        logic [DELAY_BITS-1:0] off_elapsed;
        logic                  motor;
    } state_t;

endpackage

`default_nettype wire

@@ design/rusd_if.sv @@
// Valid/ready channel interfaces for items and results.
`default_nettype none

interface rusd_item_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] bus_address;
    logic [31:0] bus_value;

    modport source (output valid, output action, output bus_address, output bus_value,
                    input ready);
    modport sink   (input valid, input action, input bus_address, input bus_value,
                    output ready);
endinterface

interface rusd_result_if;
    logic       valid;
    logic       ready;
    logic       motor_on;
    logic [2:0] sequence_stage;
    logic       commit_seen;

    modport source (output valid, output motor_on, output sequence_stage,
                    output commit_seen, input ready);
    modport sink   (input valid, input motor_on, input sequence_stage,
                    input commit_seen, output ready);
endinterface

`default_nettype wire

@@ design/rusd_step.sv @@
// One-item state update: unlock sequence FSM, commit, tick counter, release.
// Depends on rusd_pkg.
`default_nettype none

module rusd_step (
    input  wire rusd_pkg::item_t                 item,
    input  wire rusd_pkg::state_t                state,
    input  wire logic [rusd_pkg::CFG_BITS-1:0]   off_delay,
    output rusd_pkg::state_t                     state_next,
    output rusd_pkg::result_t                    result
);

    logic                  is_write;
    logic [15:0]           v;
    logic [7:0]            b;
    logic [31:0]           addr;
    rusd_pkg::stage_t      stage_nx;
    rusd_pkg::mode_t       mode_nx;
    logic                  commit;
    logic                  armed_nx;
    logic [rusd_pkg::DELAY_BITS-1:0] elapsed_nx;
    logic                  motor_nx;
    logic                  release_now;

    assign is_write = (item.action == rusd_pkg::ACT_WRITE);
    assign addr     = item.bus_address;
    assign v        = item.bus_value[15:0];
    assign b        = item.bus_value[7:0];

    // Stage next-state: any non-matching write drops back to idle
    always_comb
    begin
        stage_nx = state.stage;
        if (is_write)
        begin
            stage_nx = rusd_pkg::ST_IDLE;
            unique case (state.stage)
                rusd_pkg::ST_IDLE:
                begin
                    if (addr == rusd_pkg::A_START && v == rusd_pkg::V_D200)
                        stage_nx = rusd_pkg::ST_STEP1;
                    else if (addr == rusd_pkg::A_SELECT && v == rusd_pkg::V_SHORTCUT)
                        stage_nx = rusd_pkg::ST_CMT;
                end
                rusd_pkg::ST_STEP1:
                begin
                    if (addr == rusd_pkg::A_STEP1 && v == rusd_pkg::V_1500)
                        stage_nx = rusd_pkg::ST_STEP2;
                end
                rusd_pkg::ST_STEP2:
                begin
                    if (addr == rusd_pkg::A_STEP2 && v == rusd_pkg::V_D200)
                        stage_nx = rusd_pkg::ST_STEP3;
                end
                rusd_pkg::ST_STEP3:
                begin
                    if (addr == rusd_pkg::A_STEP3 && v == rusd_pkg::V_1500)
                        stage_nx = rusd_pkg::ST_SEL;
                end
                rusd_pkg::ST_SEL:
                begin
                    if (addr == rusd_pkg::A_SELECT &&
                        (v == rusd_pkg::V_SEL_F1 || b == rusd_pkg::B_SEL_7 ||
                         b == rusd_pkg::B_SEL_8))
                        stage_nx = rusd_pkg::ST_CMT;
                end
                rusd_pkg::ST_CMT:
                begin
                    if (addr == rusd_pkg::A_COMMIT && v == rusd_pkg::V_1500)
                        stage_nx = rusd_pkg::ST_END;
                end
                rusd_pkg::ST_END:
                begin
                    if (addr == rusd_pkg::A_END_CMD)
                        stage_nx = rusd_pkg::ST_END;
                end
                default:
                    stage_nx = rusd_pkg::ST_IDLE;
            endcase
        end
    end

    // FSM outputs: commit strobe and mode selection
    always_comb
    begin
        commit  = 1'b0;
        mode_nx = state.mode;
        if (is_write)
        begin
            unique case (state.stage)
                rusd_pkg::ST_IDLE:
                begin
                    if (!(addr == rusd_pkg::A_START && v == rusd_pkg::V_D200) &&
                        addr == rusd_pkg::A_SELECT && v == rusd_pkg::V_SHORTCUT)
                        mode_nx = rusd_pkg::MODE_OFF;
                end
                rusd_pkg::ST_CMT:
                begin
                    if (addr == rusd_pkg::A_COMMIT && v == rusd_pkg::V_1500)
                        commit = 1'b1;
                end
                rusd_pkg::ST_END:
                begin
                    if (addr == rusd_pkg::A_END_CMD)
                    begin
                        commit  = 1'b1;
                        mode_nx = (b == rusd_pkg::B_MODE_ON) ? rusd_pkg::MODE_ON
                                                             : rusd_pkg::MODE_OFF;
                    end
                end
                default:
                begin
                    commit  = 1'b0;
                    mode_nx = state.mode;
                end
            endcase
        end
    end

    // Commit action and tick counter (saturating)
    always_comb
    begin
        armed_nx   = state.off_armed;
        elapsed_nx = state.off_elapsed;
        motor_nx   = state.motor;
        if (!is_write)
        begin
            if (state.off_armed && state.off_elapsed != '1)
                elapsed_nx = state.off_elapsed + 1'b1;
        end
        else if (commit)
        begin
            if (mode_nx == rusd_pkg::MODE_ON)
                motor_nx = 1'b1;
            else if (mode_nx == rusd_pkg::MODE_OFF)
            begin
                armed_nx   = 1'b1;
                elapsed_nx = '0;
            end
        end
    end

    // Release once the armed counter has passed off_delay
    assign release_now = (mode_nx == rusd_pkg::MODE_OFF) && armed_nx &&
                         (rusd_pkg::CMP_W'(elapsed_nx) > rusd_pkg::CMP_W'(off_delay));

    always_comb
    begin
        state_next.stage       = stage_nx;
        state_next.mode        = mode_nx;
        state_next.off_armed   = armed_nx;
        state_next.off_elapsed = elapsed_nx;
        state_next.motor       = release_now ? 1'b0 : motor_nx;

        result.motor_on       = state_next.motor;
        result.sequence_stage = stage_nx;
        result.commit_seen    = commit;
    end

endmodule

`default_nettype wire

@@ design/rumble_unlock_sequence_detector.sv @@
// Rumble unlock sequence detector:
//
// Channels: "item" takes one beat per bus write (action 0) or one-millisecond
// tick (action 1); "result" gives one beat per item with the motor level, the
// sequence stage and a commit flag. Both are valid/ready; a beat moves on a
// rising edge with valid and ready high. off_delay is loaded through
// off_delay_wr_en/off_delay_wr_data and should only change while idle.
//
// Path: an accepted item is registered in the input register, passes the
// combinational state update and is registered in the result register.
// Throughput: one item per cycle while results are taken; the state update
// between the input register and the result register is combinational.
//
// Reset: stage idle, no mode, counter disarmed and cleared, motor off,
// off_delay 400, both pipeline registers empty.
// Stall: while the result is not taken, one more item is held in the input
// register; after that item.ready drops until the result moves.
//
// Depends on rusd_pkg, rusd_if, rusd_step and the assertion macro header.
`default_nettype none

`include "rumble_unlock_sequence_detector_macros.svh"

module rumble_unlock_sequence_detector (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rusd_item_if.sink                          item,
    rusd_result_if.source                      result,
    input  wire logic                          off_delay_wr_en,
    input  wire logic [rusd_pkg::CFG_BITS-1:0] off_delay_wr_data
);

    logic                        in_valid_reg;
    rusd_pkg::item_t             in_item_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    rusd_pkg::result_t           out_reg;
    rusd_pkg::state_t            state_reg;
    rusd_pkg::state_t            state_next;
    rusd_pkg::result_t           step_result;
    logic [rusd_pkg::CFG_BITS-1:0] off_delay_reg;
    logic                        advance;
    logic                        take;

    // Pipeline flow control
    assign advance        = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready     = !in_valid_reg || advance;
    assign take           = item.valid && item.ready;
    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            off_delay_reg <= rusd_pkg::OFF_DELAY_RST;
        else if (off_delay_wr_en)
            off_delay_reg <= off_delay_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg.action      <= item.action;
            in_item_reg.bus_address <= item.bus_address;
            in_item_reg.bus_value   <= item.bus_value;
        end
    end

    // Per-item state update
    rusd_step u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .off_delay  (off_delay_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.stage       <= rusd_pkg::ST_IDLE;
            state_reg.mode        <= rusd_pkg::MODE_NONE;
            state_reg.off_armed   <= 1'b0;
            state_reg.off_elapsed <= '0;
            state_reg.motor       <= 1'b0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= step_result;
    end

    assign result.valid          = out_valid_reg;
    assign result.motor_on       = out_reg.motor_on;
    assign result.sequence_stage = out_reg.sequence_stage;
    assign result.commit_seen    = out_reg.commit_seen;

    // Checks
    `RUSD_ASSERT_IMPL(a_commit_at_end, clk, rst_n, out_valid_reg && out_reg.commit_seen, out_reg.sequence_stage == rusd_pkg::ST_END)
    `RUSD_ASSERT_NEXT(a_state_holds, clk, rst_n, !advance, $stable(state_reg))
    `RUSD_ASSERT_IMPL(a_motor_needs_on, clk, rst_n, $rose(state_reg.motor), state_reg.mode == rusd_pkg::MODE_ON)
    `RUSD_ASSERT_NEXT(a_advance_fills, clk, rst_n, advance, out_valid_reg)

endmodule

`default_nettype wire
